// ----- rtl/core/hgcd_pkg.sv -----
// hgcd_pkg: constants, angle table and helpers for the great-circle distance unit
// no dependencies; imported by haversine_great_circle_distance_unit
package hgcd_pkg;

  localparam int CORDIC_STAGES_DEF = 28;
  localparam int LANES             = 4;
  localparam int SQRT_STEPS        = 31;
  localparam int CW                = 34;

  // lane codes: two half differences, two latitudes
  localparam int LANE_DLAT = 0;
  localparam int LANE_DLON = 1;
  localparam int LANE_LAT1 = 2;
  localparam int LANE_LAT2 = 3;

  localparam logic [28:0] RADIUS_RESET = 29'd416596119;
  localparam logic [31:0] PI_Q         = 32'd3373259426;
  localparam logic [31:0] DEG_180      = 32'd3019898880;
  localparam logic [31:0] DEG_90       = 32'd1509949440;
  localparam logic [31:0] DEG_45       = 32'd754974720;
  localparam logic [37:0] DIV45_RECIP  = 38'd195468733827;
  localparam logic signed [CW-1:0] GAIN_Q = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q  = 34'sd1073741824;
  localparam logic [30:0] DIST_MAX     = 31'h7fffffff;

  // atan(2^-i) in Q2.30, rounded
  function automatic logic signed [CW-1:0] atan_q(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      default: begin
        if (i <= 30) v = 34'sd1 <<< (30 - i);
        else if (i == 31) v = 34'sd1;
        else v = 34'sd0;
      end
    endcase
    return v;
  endfunction

  // Q30 product rounded half up
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v < 0) r = 32'sd0;
    else if (v > ONE_Q) r = 32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/haversine_great_circle_distance_unit.sv -----
// haversine_great_circle_distance_unit: pipelined fixed-point haversine distance
// one transaction per cycle while the output is not stalled
// pipeline depth set by the rotation and vectoring cordic chains and the 31-step root pipes
// a stall on the output holds every stage; nothing is dropped or repeated
// rst_n (synchronous) clears all valid bits and loads the default radius
// depends on hgcd_pkg
module haversine_great_circle_distance_unit #(
  parameter int CORDIC_STAGES = hgcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_longitude[31:0], first_latitude[62:32], second_longitude[94:63],
  // second_latitude[125:95], zero fill[127:126]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance[30:0], zero fill[31]
  output logic [31:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [28:0]  cfg_data
);
  import hgcd_pkg::*;

  logic en;
  logic [28:0] radius_r;

  logic out_valid_r;
  logic [30:0] out_data_r;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  // input register
  logic v0_r;
  logic signed [31:0] lon1_r, lon2_r;
  logic signed [30:0] lat1_r, lat2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lon1_r <= in_tdata[31:0];
      lat1_r <= in_tdata[62:32];
      lon2_r <= in_tdata[94:63];
      lat2_r <= in_tdata[125:95];
    end
  end

  // magnitudes of differences and latitudes
  logic v1_r;
  logic [32:0] m1_r [LANES];
  logic signed [33:0] d_nxt [LANES];

  always_comb begin
    d_nxt[LANE_DLAT] = 34'(lat2_r) - 34'(lat1_r);
    d_nxt[LANE_DLON] = 34'(lon2_r) - 34'(lon1_r);
    d_nxt[LANE_LAT1] = 34'(lat1_r);
    d_nxt[LANE_LAT2] = 34'(lat2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        m1_r[l] <= d_nxt[l][33] ? 33'(-d_nxt[l]) : d_nxt[l][32:0];
      end
    end
  end

  // reduce modulo a full period
  logic v2_r;
  logic [31:0] m2_r [LANES];
  logic [32:0] sub2_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sub2_nxt[l] = m1_r[l] - {1'b0, DEG_180};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        m2_r[l] <= (m1_r[l] >= {1'b0, DEG_180}) ? sub2_nxt[l][31:0] : m1_r[l][31:0];
      end
    end
  end

  // fold into half a period
  logic v3_r;
  logic [30:0] m3_r [LANES];
  logic [31:0] sub3_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sub3_nxt[l] = DEG_180 - m2_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        m3_r[l] <= (m2_r[l] > DEG_90) ? sub3_nxt[l][30:0] : m2_r[l][30:0];
      end
    end
  end

  // latitudes: fold into a quarter, note the cosine sign, go to 2^-24 degree
  logic v4_r;
  logic [30:0] m4_r [LANES];
  logic ng4_r [LANES];
  logic [30:0] fold4_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fold4_nxt[l] = DEG_90[30:0] - m3_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        if (l == LANE_LAT1 || l == LANE_LAT2) begin
          if (m3_r[l] > DEG_45[30:0]) begin
            ng4_r[l] <= 1'b1;
            m4_r[l]  <= {fold4_nxt[l][29:0], 1'b0};
          end else begin
            ng4_r[l] <= 1'b0;
            m4_r[l]  <= {m3_r[l][29:0], 1'b0};
          end
        end else begin
          ng4_r[l] <= 1'b0;
          m4_r[l]  <= m3_r[l];
        end
      end
    end
  end

  // degrees to radians: times pi, then divide by 180 * 2^24
  logic v5_r, v6_r, v7_r, v8_r;
  logic [62:0] p5_r [LANES];
  logic [36:0] n6_r [LANES];
  logic [55:0] ph7_r [LANES];
  logic [55:0] pl7_r [LANES];
  logic signed [CW-1:0] z8_r [LANES];
  logic ng5_r [LANES];
  logic ng6_r [LANES];
  logic ng7_r [LANES];
  logic ng8_r [LANES];
  logic [62:0] rnd6_nxt [LANES];
  logic [74:0] sum8_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rnd6_nxt[l] = p5_r[l] + {31'b0, DEG_90};
      sum8_nxt[l] = {ph7_r[l], 19'b0} + {19'b0, pl7_r[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        p5_r[l]  <= {32'b0, m4_r[l]} * {31'b0, PI_Q};
        n6_r[l]  <= rnd6_nxt[l][62:26];
        // divide by 45 through a reciprocal, split in two partial products
        ph7_r[l] <= {19'b0, n6_r[l]} * {37'b0, DIV45_RECIP[37:19]};
        pl7_r[l] <= {19'b0, n6_r[l]} * {37'b0, DIV45_RECIP[18:0]};
        z8_r[l]  <= {2'b0, sum8_nxt[l][74:43]};
        ng5_r[l] <= ng4_r[l];
        ng6_r[l] <= ng5_r[l];
        ng7_r[l] <= ng6_r[l];
        ng8_r[l] <= ng7_r[l];
      end
    end
  end

  // rotation cordic, four lanes, one stage per register
  logic signed [CW-1:0] rx_r [CORDIC_STAGES][LANES];
  logic signed [CW-1:0] ry_r [CORDIC_STAGES][LANES];
  logic signed [CW-1:0] rz_r [CORDIC_STAGES][LANES];
  logic rng_r [CORDIC_STAGES][LANES];
  logic rv_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    localparam logic signed [CW-1:0] ATAN = atan_q(i);
    logic signed [CW-1:0] xi [LANES];
    logic signed [CW-1:0] yi [LANES];
    logic signed [CW-1:0] zi [LANES];
    logic ni [LANES];
    logic vi;
    if (i == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          xi[l] = GAIN_Q;
          yi[l] = '0;
          zi[l] = z8_r[l];
          ni[l] = ng8_r[l];
        end
        vi = v8_r;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          xi[l] = rx_r[i-1][l];
          yi[l] = ry_r[i-1][l];
          zi[l] = rz_r[i-1][l];
          ni[l] = rng_r[i-1][l];
        end
        vi = rv_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          if (zi[l] >= 0) begin
            rx_r[i][l] <= xi[l] - (yi[l] >>> i);
            ry_r[i][l] <= yi[l] + (xi[l] >>> i);
            rz_r[i][l] <= zi[l] - ATAN;
          end else begin
            rx_r[i][l] <= xi[l] + (yi[l] >>> i);
            ry_r[i][l] <= yi[l] - (xi[l] >>> i);
            rz_r[i][l] <= zi[l] + ATAN;
          end
          rng_r[i][l] <= ni[l];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[i] <= 1'b0;
      end else if (en) begin
        rv_r[i] <= vi;
      end
    end
  end

  // clamp: sines for the half differences, signed cosines for the latitudes
  logic vc_r;
  logic signed [31:0] u_r [LANES];
  logic signed [31:0] cl_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (l == LANE_LAT1 || l == LANE_LAT2) begin
        cl_nxt[l] = clamp_unit(rx_r[CORDIC_STAGES-1][l]);
      end else begin
        cl_nxt[l] = clamp_unit(ry_r[CORDIC_STAGES-1][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        u_r[l] <= rng_r[CORDIC_STAGES-1][l] ? -cl_nxt[l] : cl_nxt[l];
      end
    end
  end

  // a = sin^2(dlat/2) + sin^2(dlon/2) * cos(lat1) * cos(lat2)
  logic vm1_r, vm2_r, va_r;
  logic signed [31:0] slat1_r, slon1_r, cc1_r, slat2_r, t2_r;
  logic [30:0] a_r;
  logic signed [32:0] asum_nxt;
  logic signed [31:0] a_nxt;

  assign asum_nxt = 33'(slat2_r) + 33'(t2_r);
  assign a_nxt    = clamp_unit(CW'(asum_nxt));

  always_ff @(posedge clk) begin
    if (en) begin
      slat1_r <= qmul(u_r[LANE_DLAT], u_r[LANE_DLAT]);
      slon1_r <= qmul(u_r[LANE_DLON], u_r[LANE_DLON]);
      cc1_r   <= qmul(u_r[LANE_LAT1], u_r[LANE_LAT2]);
      slat2_r <= slat1_r;
      t2_r    <= qmul(slon1_r, cc1_r);
      a_r     <= a_nxt[30:0];
    end
  end

  // two floor square roots, one result bit per stage
  logic [61:0] sv_r [SQRT_STEPS][2];
  logic [61:0] sr_r [SQRT_STEPS][2];
  logic sqv_r [SQRT_STEPS];
  logic [30:0] oma_nxt;

  assign oma_nxt = ONE_Q[30:0] - a_r;

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (2 * (SQRT_STEPS - 1 - s));
    logic [61:0] vi [2];
    logic [61:0] ri [2];
    logic [61:0] ti [2];
    logic qi;
    if (s == 0) begin : g_first
      always_comb begin
        vi[0] = {1'b0, a_r, 30'b0};
        vi[1] = {1'b0, oma_nxt, 30'b0};
        ri[0] = '0;
        ri[1] = '0;
        qi    = va_r;
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 2; k++) begin
          vi[k] = sv_r[s-1][k];
          ri[k] = sr_r[s-1][k];
        end
        qi = sqv_r[s-1];
      end
    end
    always_comb begin
      for (int k = 0; k < 2; k++) begin
        ti[k] = ri[k] + BIT;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 2; k++) begin
          if (vi[k] >= ti[k]) begin
            sv_r[s][k] <= vi[k] - ti[k];
            sr_r[s][k] <= (ri[k] >> 1) + BIT;
          end else begin
            sv_r[s][k] <= vi[k];
            sr_r[s][k] <= ri[k] >> 1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[s] <= 1'b0;
      end else if (en) begin
        sqv_r[s] <= qi;
      end
    end
  end

  // vectoring cordic: angle of (sqrt(1 - a), sqrt(a))
  logic signed [CW-1:0] ax_r [CORDIC_STAGES];
  logic signed [CW-1:0] ay_r [CORDIC_STAGES];
  logic signed [CW-1:0] az_r [CORDIC_STAGES];
  logic av_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_arc
    localparam logic signed [CW-1:0] ATAN = atan_q(i);
    logic signed [CW-1:0] xi, yi, zi;
    logic vi;
    if (i == 0) begin : g_first
      always_comb begin
        xi = {3'b0, sr_r[SQRT_STEPS-1][1][30:0]};
        yi = {3'b0, sr_r[SQRT_STEPS-1][0][30:0]};
        zi = '0;
        vi = sqv_r[SQRT_STEPS-1];
      end
    end else begin : g_next
      always_comb begin
        xi = ax_r[i-1];
        yi = ay_r[i-1];
        zi = az_r[i-1];
        vi = av_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          ax_r[i] <= xi + (yi >>> i);
          ay_r[i] <= yi - (xi >>> i);
          az_r[i] <= zi + ATAN;
        end else begin
          ax_r[i] <= xi - (yi >>> i);
          ay_r[i] <= yi + (xi >>> i);
          az_r[i] <= zi - ATAN;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        av_r[i] <= 1'b0;
      end else if (en) begin
        av_r[i] <= vi;
      end
    end
  end

  // c = 2 * angle, distance = round(radius * c), saturated
  logic vf1_r, vf2_r;
  logic [33:0] c_r;
  logic [32:0] d_r;
  logic [62:0] prod_nxt;
  logic signed [CW-1:0] zend;

  assign zend     = az_r[CORDIC_STAGES-1];
  assign prod_nxt = {34'b0, radius_r} * {29'b0, c_r} + 63'd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= (zend < 0) ? 34'd0 : {zend[32:0], 1'b0};
      d_r <= prod_nxt[62:30];
      out_data_r <= (d_r > {2'b0, DIST_MAX}) ? DIST_MAX : d_r[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      vc_r        <= 1'b0;
      vm1_r       <= 1'b0;
      vm2_r       <= 1'b0;
      va_r        <= 1'b0;
      vf1_r       <= 1'b0;
      vf2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_tvalid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      vc_r        <= rv_r[CORDIC_STAGES-1];
      vm1_r       <= vc_r;
      vm2_r       <= vm1_r;
      va_r        <= vm2_r;
      vf1_r       <= av_r[CORDIC_STAGES-1];
      vf2_r       <= vf1_r;
      out_valid_r <= vf2_r;
    end
  end

`ifndef SYNTHESIS
  // an accepted transaction shows up in the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v0_r)
    else $error("accepted transaction missing from first stage");

  // a new result comes only from a valid last stage
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vf2_r))
    else $error("result without a valid source stage");

  // a radius write takes effect on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> (radius_r == $past(cfg_data)))
    else $error("radius write lost");

  // the haversine term stays within the unit range feeding the roots
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(vm2_r && en) |-> (a_r <= ONE_Q[30:0]))
    else $error("haversine term out of range");
`endif

endmodule
